[rtl/ppp_afe_pkg.sv]
// Package for the PPP asynchronous frame encoder.
// Holds line constants, the queue entry type and the CRC and escape helpers.
// No dependencies.
package ppp_afe_pkg;

   localparam int BYTE_W      = 8;
   localparam int CRC_W       = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7e;
   localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7d;
   localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;
   localparam logic [BYTE_W-1:0] CTRL_LIM  = 8'h20;
   localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8408;
   localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hffff;

   // One classified payload byte, with the FCS already complemented
   typedef struct packed {
      logic              open_flag;
      logic [BYTE_W-1:0] data_byte;
      logic              frame_end;
      logic [CRC_W-1:0]  fcs;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   function automatic logic needs_escape(input logic [BYTE_W-1:0] b);
      return (b < CTRL_LIM) || (b == ESC_BYTE) || (b == FLAG_BYTE);
   endfunction

   function automatic logic [BYTE_W-1:0] escaped_value(input logic [BYTE_W-1:0] b);
      return needs_escape(b) ? (b ^ ESC_XOR) : b;
   endfunction

   // Reflected CRC-16, one byte, LSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] v_in,
                                                 input logic [BYTE_W-1:0] c_in);
      logic [CRC_W-1:0]  v;
      logic [BYTE_W-1:0] c;
      v = v_in;
      c = c_in;
      for (int j = 0; j < BYTE_W; j++) begin
         if (v[0] ^ c[0]) begin
            v = (v >> 1) ^ CRC_POLY;
         end else begin
            v = v >> 1;
         end
         c = c >> 1;
      end
      return v;
   endfunction

endpackage

[rtl/ppp_afe_if.sv]
// Handshake channel interfaces for the PPP asynchronous frame encoder.
// Depends on ppp_afe_pkg for field widths.
interface ppp_afe_req_if;
   logic                             valid;
   logic                             ready;
   logic [ppp_afe_pkg::BYTE_W-1:0]   data_byte;
   logic                             frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface ppp_afe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ppp_afe_pkg::BYTE_W-1:0]   line_byte;
   logic                             run_last;

   modport source (output valid, output line_byte, output run_last, input ready);
   modport sink   (input valid, input line_byte, input run_last, output ready);
endinterface

[rtl/ppp_afe_front.sv]
// Front end: accepts payload transactions, runs the CRC and builds queue entries.
// Depends on ppp_afe_pkg and ppp_afe_req_if.
module ppp_afe_front (
   input  logic                   clock,
   input  logic                   reset,
   ppp_afe_req_if.sink            req_chan,
   input  logic                   q_full,
   output ppp_afe_pkg::push_type  push
);

   logic [ppp_afe_pkg::CRC_W-1:0] crc_ff, crc_in, crc_next;
   logic                          in_frame_ff, in_frame_in;
   logic                          accept;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   always_comb begin
      crc_next    = ppp_afe_pkg::crc_byte(crc_ff, req_chan.data_byte);
      crc_in      = crc_ff;
      in_frame_in = in_frame_ff;
      if (accept) begin
         crc_in      = req_chan.frame_end ? ppp_afe_pkg::CRC_INIT : crc_next;
         in_frame_in = !req_chan.frame_end;
      end
      push.valid           = accept;
      push.entry.open_flag = !in_frame_ff;
      push.entry.data_byte = req_chan.data_byte;
      push.entry.frame_end = req_chan.frame_end;
      push.entry.fcs       = ~crc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= ppp_afe_pkg::CRC_INIT;
         in_frame_ff <= 1'b0;
      end else begin
         crc_ff      <= crc_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

[rtl/ppp_afe_queue.sv]
// Short FIFO of classified entries between front and back ends.
// Depends on ppp_afe_pkg.
module ppp_afe_queue #(
   parameter int DEPTH = ppp_afe_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppp_afe_pkg::push_type   push,
   input  logic                    pop,
   output logic                    full,
   output logic                    head_valid,
   output ppp_afe_pkg::entry_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ppp_afe_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/ppp_afe_back.sv]
// Back end: walks each queue entry and emits one line byte per cycle while rsp_chan
// is ready, through a registered output stage. Depends on ppp_afe_pkg and ppp_afe_rsp_if.
module ppp_afe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  ppp_afe_pkg::entry_type  head,
   output logic                    pop,
   ppp_afe_rsp_if.source           rsp_chan
);

   typedef enum logic [2:0] {
      ST_OPEN, ST_DESC, ST_DATA, ST_LESC, ST_LO, ST_HESC, ST_HI, ST_CLOSE
   } step_type;

   step_type step_ff, step_in, first_step, cur_step;
   logic     fresh_ff, fresh_in;
   logic     out_valid_ff, out_valid_in;
   logic     out_last_ff, out_last_in;
   logic [ppp_afe_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in, cur_byte, fcs_lo, fcs_hi;
   logic     done, advance;

   assign fcs_lo  = head.fcs[7:0];
   assign fcs_hi  = head.fcs[15:8];
   assign advance = head_valid && (!out_valid_ff || rsp_chan.ready);
   assign pop     = advance && done;

   always_comb begin
      first_step = head.open_flag ? ST_OPEN :
                   (ppp_afe_pkg::needs_escape(head.data_byte) ? ST_DESC : ST_DATA);
      cur_step   = fresh_ff ? first_step : step_ff;
      step_in    = cur_step;
      done       = 1'b0;
      cur_byte   = ppp_afe_pkg::FLAG_BYTE;
      unique case (cur_step)
         ST_OPEN: begin
            step_in = ppp_afe_pkg::needs_escape(head.data_byte) ? ST_DESC : ST_DATA;
         end
         ST_DESC: begin
            cur_byte = ppp_afe_pkg::ESC_BYTE;
            step_in  = ST_DATA;
         end
         ST_DATA: begin
            cur_byte = ppp_afe_pkg::escaped_value(head.data_byte);
            if (head.frame_end) begin
               step_in = ppp_afe_pkg::needs_escape(fcs_lo) ? ST_LESC : ST_LO;
            end else begin
               done = 1'b1;
            end
         end
         ST_LESC: begin
            cur_byte = ppp_afe_pkg::ESC_BYTE;
            step_in  = ST_LO;
         end
         ST_LO: begin
            cur_byte = ppp_afe_pkg::escaped_value(fcs_lo);
            step_in  = ppp_afe_pkg::needs_escape(fcs_hi) ? ST_HESC : ST_HI;
         end
         ST_HESC: begin
            cur_byte = ppp_afe_pkg::ESC_BYTE;
            step_in  = ST_HI;
         end
         ST_HI: begin
            cur_byte = ppp_afe_pkg::escaped_value(fcs_hi);
            step_in  = ST_CLOSE;
         end
         ST_CLOSE: begin
            done = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase

      fresh_in     = fresh_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         fresh_in     = done;
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_OPEN;
         fresh_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            step_ff <= step_in;
         end
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.line_byte = out_byte_ff;
   assign rsp_chan.run_last  = out_last_ff;

endmodule

[rtl/ppp_async_frame_encoder.sv]
// Top level of the PPP asynchronous frame encoder.
// Depends on ppp_afe_pkg, the channel interfaces, ppp_afe_front, ppp_afe_queue
// and ppp_afe_back.
//
// req_chan carries payload bytes; frame_end marks the last byte of a frame.
// rsp_chan carries line bytes; run_last marks the final byte caused by one
// request transaction. A frame opens with a 0x7e flag, control bytes and
// 0x7d/0x7e are escaped as 0x7d, byte ^ 0x20, and the frame closes with the
// escaped FCS-16 (low byte first) and a 0x7e flag.
// A request is first written into the entry queue; its first line byte is then
// registered in the back end's output stage before it shows on rsp_chan.
// Throughput: one line byte per cycle while rsp_chan is ready, set by the
// back end's output register; a request gives 1 to 8 bytes (2 if escaped).
// The front end takes a request every cycle while the entry queue has room.
// Reset clears the CRC, frame state, queue and output stage; no clearing pass.
// When rsp_chan stalls, the output byte holds, the queue fills and req_chan.ready
// drops once QUEUE_DEPTH entries wait.
module ppp_async_frame_encoder #(
   parameter int QUEUE_DEPTH = ppp_afe_pkg::QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   ppp_afe_req_if.sink   req_chan,
   ppp_afe_rsp_if.source rsp_chan
);

   ppp_afe_pkg::push_type  push;
   ppp_afe_pkg::entry_type head;
   logic                   q_full, head_valid, pop;

   ppp_afe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   ppp_afe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   ppp_afe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

[rtl/ppp_afe_checker.sv]
// Port-level checks for the PPP asynchronous frame encoder, bound to the top level.
// Depends on ppp_afe_pkg and ppp_async_frame_encoder.
module ppp_afe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ppp_afe_pkg::BYTE_W-1:0] rsp_line_byte,
   input logic                           rsp_run_last
);

   // stalled transaction keeps its valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_line_byte) && $stable(rsp_run_last))
      else $error("rsp payload changed while stalled");

   // an escape byte is never marked as the last byte of a request
   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_byte == ppp_afe_pkg::ESC_BYTE) |-> !rsp_run_last)
      else $error("escape byte marked as last");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

endmodule

bind ppp_async_frame_encoder ppp_afe_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_line_byte (rsp_chan.line_byte),
   .rsp_run_last  (rsp_chan.run_last)
);
